>>> sv/cv3_pkg.sv
// Shared types and constants of the 3x3 RGB convolution block.
package cv3_pkg;

	localparam int PIX_W = 24;
	localparam int SUM_W = 20;
	localparam int MAG_W = 19;
	localparam int MAX_HEIGHT = 1024;
	localparam logic [7:0] PIX_MAX = 8'd255;

	localparam logic [2:0] REG_WIDTH = 3'd0;
	localparam logic [2:0] REG_HEIGHT = 3'd1;
	localparam logic [2:0] REG_DIVISOR = 3'd2;
	localparam logic [2:0] REG_KERN_TOP = 3'd3;
	localparam logic [2:0] REG_KERN_MID = 3'd4;
	localparam logic [2:0] REG_KERN_BOT = 3'd5;

	typedef logic [PIX_W-1:0] pixel_t;

	typedef struct packed {
		logic [10:0] width;
		logic [10:0] height;
	} geom_t;

	typedef struct packed {
		logic [23:0] top;
		logic [23:0] middle;
		logic [23:0] bottom;
		logic [9:0] div;
	} kern_t;

	typedef struct packed {
		logic [9:0] row;
		logic [9:0] col;
		logic last;
		pixel_t [8:0] win;
	} win_item_t;

	typedef enum logic [1:0] {
		F_CLEAR,
		F_IDLE,
		F_PROC
	} front_state_t;

	typedef enum logic [1:0] {
		B_IDLE,
		B_MAC,
		B_DIV,
		B_OUT
	} back_state_t;

endpackage

>>> sv/cv3_ifs.sv
// Channel interfaces of the 3x3 RGB convolution block.
interface cv3_pix_if;
	logic valid;
	logic ready;
	logic frame_start;
	logic [7:0] red_in;
	logic [7:0] green_in;
	logic [7:0] blue_in;
	modport source(output valid, frame_start, red_in, green_in, blue_in, input ready);
	modport sink(input valid, frame_start, red_in, green_in, blue_in, output ready);
endinterface

interface cv3_res_if;
	logic valid;
	logic ready;
	logic [9:0] out_row;
	logic [9:0] out_col;
	logic [7:0] red_out;
	logic [7:0] green_out;
	logic [7:0] blue_out;
	logic frame_last;
	modport source(output valid, out_row, out_col, red_out, green_out, blue_out, frame_last,
		input ready);
	modport sink(input valid, out_row, out_col, red_out, green_out, blue_out, frame_last,
		output ready);
endinterface

interface cv3_cfg_if;
	logic valid;
	logic ready;
	logic [2:0] index;
	logic [23:0] data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

>>> sv/cv3_front.sv
// Front end: position counters, line stores, window and interior classification.
module cv3_front #(
	parameter int MAX_WIDTH = 1024
) (
	input logic clk,
	input logic arst_n,
	cv3_pix_if.sink pix,
	input cv3_pkg::geom_t geom,
	input logic fifo_full,
	output logic push_valid,
	output cv3_pkg::win_item_t push_item
);
	localparam int CW = $clog2(MAX_WIDTH);

	cv3_pkg::front_state_t state_q, state_d;

	logic [47:0] mem [MAX_WIDTH];
	logic [47:0] rd_q;
	logic mem_we;
	logic [CW-1:0] mem_wa;
	logic [47:0] mem_wd;

	logic [CW-1:0] clr_q;
	logic [CW-1:0] col_q;
	logic [9:0] row_q;
	logic [CW-1:0] c_q;
	logic [9:0] r_q;
	cv3_pkg::pixel_t pix_q;
	cv3_pkg::pixel_t [8:0] win_q;
	cv3_pkg::pixel_t [8:0] win_d;

	logic accept;
	logic clr_last;
	logic [CW-1:0] c_in;
	logic [9:0] r_in;
	logic [11:0] c_ext;
	logic [11:0] w_ext;
	logic [10:0] r_ext;
	logic emit;
	logic col_wrap;

	assign accept = pix.valid && pix.ready;
	assign clr_last = (clr_q == CW'(MAX_WIDTH - 1));
	assign c_in = pix.frame_start ? '0 : col_q;
	assign r_in = pix.frame_start ? '0 : row_q;
	assign c_ext = 12'(c_q);
	assign w_ext = {1'b0, geom.width};
	assign r_ext = {1'b0, r_q};
	assign emit = (r_q >= 10'd2) && (c_ext >= 12'd2) && (r_ext < geom.height)
		&& (c_ext < w_ext);
	assign col_wrap = (c_ext + 12'd1) >= w_ext;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			cv3_pkg::F_CLEAR: if (clr_last) state_d = cv3_pkg::F_IDLE;
			cv3_pkg::F_IDLE: if (accept) state_d = cv3_pkg::F_PROC;
			cv3_pkg::F_PROC: state_d = cv3_pkg::F_IDLE;
			default: state_d = cv3_pkg::F_CLEAR;
		endcase
	end

	always_comb begin
		pix.ready = 1'b0;
		mem_we = 1'b0;
		mem_wa = c_q;
		mem_wd = {rd_q[23:0], pix_q};
		push_valid = 1'b0;
		unique case (state_q)
			cv3_pkg::F_CLEAR: begin
				mem_we = 1'b1;
				mem_wa = clr_q;
				mem_wd = '0;
			end
			cv3_pkg::F_IDLE: pix.ready = !fifo_full;
			cv3_pkg::F_PROC: begin
				mem_we = 1'b1;
				push_valid = emit;
			end
			default: ;
		endcase
	end

	// Upper store sits in bits 47:24, lower store in bits 23:0 of each entry.
	always_comb begin
		win_d[0] = win_q[1];
		win_d[1] = win_q[2];
		win_d[2] = rd_q[47:24];
		win_d[3] = win_q[4];
		win_d[4] = win_q[5];
		win_d[5] = rd_q[23:0];
		win_d[6] = win_q[7];
		win_d[7] = win_q[8];
		win_d[8] = pix_q;
	end

	assign push_item.row = r_q - 10'd1;
	assign push_item.col = 10'(c_ext - 12'd1);
	assign push_item.last = (r_ext == geom.height - 11'd1) && (c_ext == w_ext - 12'd1);
	assign push_item.win = win_d;

	always_ff @(posedge clk) begin
		if (mem_we) mem[mem_wa] <= mem_wd;
		if (accept) rd_q <= mem[c_in];
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			c_q <= c_in;
			r_q <= r_in;
			pix_q <= {pix.blue_in, pix.green_in, pix.red_in};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cv3_pkg::F_CLEAR;
			clr_q <= '0;
			col_q <= '0;
			row_q <= '0;
			win_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == cv3_pkg::F_CLEAR) clr_q <= clr_q + CW'(1);
			if (state_q == cv3_pkg::F_PROC) begin
				win_q <= win_d;
				if (col_wrap) begin
					col_q <= '0;
					row_q <= ((r_ext + 11'd1) >= geom.height) ? '0 : r_q + 10'd1;
				end else begin
					col_q <= CW'(c_ext + 12'd1);
					row_q <= r_q;
				end
			end
		end
	end
endmodule

>>> sv/cv3_queue.sv
// Two-entry queue that carries windows from the front end to the arithmetic back end.
module cv3_queue (
	input logic clk,
	input logic arst_n,
	input logic push,
	input cv3_pkg::win_item_t push_item,
	output logic full,
	output logic head_valid,
	output cv3_pkg::win_item_t head_item,
	input logic pop
);
	cv3_pkg::win_item_t slot_q [2];
	logic wr_ptr_q;
	logic rd_ptr_q;
	logic [1:0] cnt_q;

	assign full = (cnt_q == 2'd2);
	assign head_valid = (cnt_q != 2'd0);
	assign head_item = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_ptr_q] <= push_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop) rd_ptr_q <= !rd_ptr_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule

>>> sv/cv3_back.sv
// Back end: per-plane multiply-accumulate, restoring division and clamping.
module cv3_back (
	input logic clk,
	input logic arst_n,
	input logic head_valid,
	input cv3_pkg::win_item_t head_item,
	output logic pop,
	input cv3_pkg::kern_t kern,
	cv3_res_if.source res
);
	cv3_pkg::back_state_t state_q, state_d;
	cv3_pkg::win_item_t item_q;
	logic [3:0] k_q;
	logic [4:0] step_q;
	logic signed [cv3_pkg::SUM_W-1:0] acc_q [3];
	logic [9:0] rem_q [3];
	logic [cv3_pkg::MAG_W-1:0] quo_q [3];

	logic [23:0] krow;
	logic [1:0] kcol;
	logic signed [7:0] tap;
	cv3_pkg::pixel_t wpix;
	logic [9:0] dvs;
	logic [4:0] bit_idx;
	logic mac_done;
	logic div_done;
	logic signed [16:0] prod [3];
	logic [cv3_pkg::MAG_W-1:0] mag [3];
	logic [10:0] rem2 [3];
	logic ge [3];
	logic [7:0] clamped [3];

	assign dvs = (kern.div == 10'd0) ? 10'd1 : kern.div;
	assign mac_done = (k_q == 4'd8);
	assign div_done = (step_q == 5'(cv3_pkg::MAG_W - 1));
	assign bit_idx = 5'(cv3_pkg::MAG_W - 1) - step_q;
	assign wpix = item_q.win[k_q];

	always_comb begin
		case (k_q) inside
			4'd0, 4'd1, 4'd2: krow = kern.top;
			4'd3, 4'd4, 4'd5: krow = kern.middle;
			default: krow = kern.bottom;
		endcase
		case (k_q) inside
			4'd0, 4'd3, 4'd6: kcol = 2'd0;
			4'd1, 4'd4, 4'd7: kcol = 2'd1;
			default: kcol = 2'd2;
		endcase
		case (kcol)
			2'd0: tap = krow[7:0];
			2'd1: tap = krow[15:8];
			default: tap = krow[23:16];
		endcase
	end

	always_comb begin
		for (int p = 0; p < 3; p++) begin
			prod[p] = $signed({1'b0, wpix[8*p +: 8]}) * tap;
			mag[p] = acc_q[p][cv3_pkg::SUM_W-1] ? cv3_pkg::MAG_W'(-acc_q[p])
				: acc_q[p][cv3_pkg::MAG_W-1:0];
			rem2[p] = {rem_q[p], mag[p][bit_idx]};
			ge[p] = (rem2[p] >= {1'b0, dvs});
			// A negative sum divides to zero or below, which clamps to zero.
			if (acc_q[p][cv3_pkg::SUM_W-1]) clamped[p] = 8'd0;
			else if (quo_q[p] > cv3_pkg::MAG_W'(cv3_pkg::PIX_MAX)) clamped[p] = cv3_pkg::PIX_MAX;
			else clamped[p] = quo_q[p][7:0];
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			cv3_pkg::B_IDLE: if (head_valid) state_d = cv3_pkg::B_MAC;
			cv3_pkg::B_MAC: if (mac_done) state_d = cv3_pkg::B_DIV;
			cv3_pkg::B_DIV: if (div_done) state_d = cv3_pkg::B_OUT;
			cv3_pkg::B_OUT: if (res.ready) state_d = cv3_pkg::B_IDLE;
			default: state_d = cv3_pkg::B_IDLE;
		endcase
	end

	always_comb begin
		pop = 1'b0;
		res.valid = 1'b0;
		unique case (state_q)
			cv3_pkg::B_IDLE: pop = head_valid;
			cv3_pkg::B_OUT: res.valid = 1'b1;
			default: ;
		endcase
	end

	assign res.out_row = item_q.row;
	assign res.out_col = item_q.col;
	assign res.frame_last = item_q.last;
	assign res.red_out = clamped[0];
	assign res.green_out = clamped[1];
	assign res.blue_out = clamped[2];

	always_ff @(posedge clk) begin
		if (pop) item_q <= head_item;
		for (int p = 0; p < 3; p++) begin
			if (pop) begin
				acc_q[p] <= '0;
			end else if (state_q == cv3_pkg::B_MAC) begin
				acc_q[p] <= acc_q[p] + cv3_pkg::SUM_W'(prod[p]);
			end
			if (state_q == cv3_pkg::B_MAC) begin
				rem_q[p] <= '0;
			end else if (state_q == cv3_pkg::B_DIV) begin
				rem_q[p] <= ge[p] ? 10'(rem2[p] - {1'b0, dvs}) : rem2[p][9:0];
				quo_q[p] <= {quo_q[p][cv3_pkg::MAG_W-2:0], ge[p]};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cv3_pkg::B_IDLE;
			k_q <= '0;
			step_q <= '0;
		end else begin
			state_q <= state_d;
			if (pop) k_q <= '0;
			else if (state_q == cv3_pkg::B_MAC) k_q <= k_q + 4'd1;
			if (state_q == cv3_pkg::B_MAC) step_q <= '0;
			else if (state_q == cv3_pkg::B_DIV) step_q <= step_q + 5'd1;
		end
	end
endmodule

>>> sv/convolution_3x3_rgb_clamp_core.sv
// The front end takes a pixel, reads the line stores, then updates the window and writes
// the stores before it takes the next. The back end takes a window, runs the multiply-accumulate
// and restoring divide steps, then holds its result until accepted before taking the next.
// The two-entry queue lets border pixels stream meanwhile.
// After reset the line stores are zeroed entry by entry; no pixel is taken then.
// Configuration registers reset to width and height 1024, divisor 1, identity kernel.
module convolution_3x3_rgb_clamp_core #(
	parameter int MAX_WIDTH = 1024
) (
	input logic clk,
	input logic arst_n,
	cv3_pix_if.sink pix,
	cv3_res_if.source res,
	cv3_cfg_if.sink cfg
);
	logic [10:0] width_q;
	logic [10:0] height_q;
	logic [9:0] div_q;
	logic [23:0] ktop_q;
	logic [23:0] kmid_q;
	logic [23:0] kbot_q;

	cv3_pkg::geom_t geom;
	cv3_pkg::kern_t kern;
	logic push_valid;
	cv3_pkg::win_item_t push_item;
	logic fifo_full;
	logic head_valid;
	cv3_pkg::win_item_t head_item;
	logic pop;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= 11'd1024;
			height_q <= 11'd1024;
			div_q <= 10'd1;
			ktop_q <= 24'd0;
			kmid_q <= 24'd256;
			kbot_q <= 24'd0;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				cv3_pkg::REG_WIDTH: width_q <= cfg.data[10:0];
				cv3_pkg::REG_HEIGHT: height_q <= cfg.data[10:0];
				cv3_pkg::REG_DIVISOR: div_q <= cfg.data[9:0];
				cv3_pkg::REG_KERN_TOP: ktop_q <= cfg.data;
				cv3_pkg::REG_KERN_MID: kmid_q <= cfg.data;
				cv3_pkg::REG_KERN_BOT: kbot_q <= cfg.data;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (width_q < 11'd3) geom.width = 11'd3;
		else if (32'(width_q) > MAX_WIDTH) geom.width = 11'(MAX_WIDTH);
		else geom.width = width_q;
		if (height_q < 11'd3) geom.height = 11'd3;
		else if (32'(height_q) > cv3_pkg::MAX_HEIGHT) geom.height = 11'(cv3_pkg::MAX_HEIGHT);
		else geom.height = height_q;
	end

	assign kern.top = ktop_q;
	assign kern.middle = kmid_q;
	assign kern.bottom = kbot_q;
	assign kern.div = div_q;

	cv3_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.pix(pix),
		.geom(geom),
		.fifo_full(fifo_full),
		.push_valid(push_valid),
		.push_item(push_item)
	);

	cv3_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push_valid),
		.push_item(push_item),
		.full(fifo_full),
		.head_valid(head_valid),
		.head_item(head_item),
		.pop(pop)
	);

	cv3_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head_valid(head_valid),
		.head_item(head_item),
		.pop(pop),
		.kern(kern),
		.res(res)
	);
endmodule
